@@ design/lsh_pkg.sv @@
package lsh_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned GainW = 16;
  localparam int unsigned LapW  = 11;
  localparam int unsigned ProdW = GainW + LapW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam logic [PixW-1:0] PixMax = 8'd255;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSharpenGain = 2'd2;

  localparam int unsigned FrameWidthW  = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned ResetWidth   = 640;
  localparam int unsigned ResetHeight  = 480;
  localparam logic signed [GainW-1:0] ResetGain = 16'sd256;

  // Stencil taps around the centre pixel.
  typedef struct packed {
    logic [PixW-1:0] up;
    logic [PixW-1:0] left;
    logic [PixW-1:0] centre;
    logic [PixW-1:0] right;
    logic [PixW-1:0] down;
  } taps_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
  } result_t;

  // Last index of a dimension after saturating it to 3..hi.
  function automatic int last_index(int v, int hi);
    if (v < 3) return 2;
    if (v > hi) return hi - 1;
    return v - 1;
  endfunction

endpackage

@@ design/lsh_line_buf.sv @@
module lsh_line_buf #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  input  logic [lsh_pkg::PixW-1:0]  pixel_i,
  output logic [lsh_pkg::PixW-1:0]  top_o,
  output logic [lsh_pkg::PixW-1:0]  mid_o
);

  logic [lsh_pkg::PixW-1:0] mid_mem [Depth];
  logic [lsh_pkg::PixW-1:0] top_mem [Depth];
  logic [lsh_pkg::PixW-1:0] mid_q;
  logic [lsh_pkg::PixW-1:0] top_q;

  // The row above moves down into the top line as the new pixel takes its place.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mid_mem[wr_addr_i] <= pixel_i;
      top_mem[wr_addr_i] <= mid_q;
    end
  end

  // Read ahead at the next column so the data is ready for the next item.
  always_ff @(posedge clk_i) begin
    mid_q <= mid_mem[rd_addr_i];
    top_q <= top_mem[rd_addr_i];
  end

  assign mid_o = mid_q;
  assign top_o = top_q;

endmodule

@@ design/lsh_kernel.sv @@
module lsh_kernel (
  input  lsh_pkg::taps_t                         taps_i,
  input  logic signed [lsh_pkg::GainW-1:0]       gain_i,
  output logic [lsh_pkg::PixW-1:0]               pixel_o
);

  logic signed [lsh_pkg::LapW-1:0]  lap;
  logic signed [lsh_pkg::ProdW-1:0] prod;
  logic signed [lsh_pkg::SumW-1:0]  total;

  assign lap = $signed(lsh_pkg::LapW'(taps_i.up)) + $signed(lsh_pkg::LapW'(taps_i.down))
             + $signed(lsh_pkg::LapW'(taps_i.left)) + $signed(lsh_pkg::LapW'(taps_i.right))
             - $signed(lsh_pkg::LapW'({taps_i.centre, 2'b00}));

  assign prod  = lsh_pkg::ProdW'(gain_i) * lsh_pkg::ProdW'(lap);
  assign total = lsh_pkg::SumW'(prod)
               + $signed(lsh_pkg::SumW'({taps_i.centre, 8'b0}));

  // Drop the fraction and saturate to the pixel range.
  always_comb begin
    if (total[lsh_pkg::SumW-1] || (total == '0)) begin
      pixel_o = '0;
    end else if (|total[lsh_pkg::SumW-2:16]) begin
      pixel_o = lsh_pkg::PixMax;
    end else begin
      pixel_o = total[15:8];
    end
  end

endmodule

@@ design/lsh_out_buf.sv @@
module lsh_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsh_pkg::result_t push_data_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output lsh_pkg::result_t out_data_o,
  output logic             full_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  lsh_pkg::result_t out_data_q, out_data_d;
  lsh_pkg::result_t skid_data_q, skid_data_d;
  logic             fire;

  assign fire = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q && !fire) begin
      // Output held: park the new item in the skid stage.
      if (push_i) begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else begin
      out_valid_d = push_i;
      if (push_i) begin
        out_data_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign full_o      = skid_valid_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid item lost while output stalled");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid stage filled without a stalled output");

endmodule

@@ design/laplacian_sharpen_3x3.sv @@
// A result is registered into the output buffer when the item that completes
// its window (the pixel below and right of the centre) is accepted.
// Throughput: one item per cycle while in_stall_o is low, set by the
// combinational kernel between the line store read register and the output
// register. Reset clears counters, window, output stages and loads default
// geometry and gain; the line store is not cleared and needs no clearing pass.
module laplacian_sharpen_3x3 #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lsh_pkg::PixW-1:0]          pixel_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lsh_pkg::PixW-1:0]          pixel_out_o,
  output logic                              frame_last_o,
  input  logic                              cfg_we_i,
  input  logic [lsh_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [lsh_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] last_col_q;
  logic [RW-1:0] last_row_q;
  logic signed [lsh_pkg::GainW-1:0] gain_q;

  logic [lsh_pkg::PixW-1:0] win_left_q, win_up_q, win_centre_q, win_down_q;
  logic [lsh_pkg::PixW-1:0] top_rd, mid_rd;

  logic             accept;
  logic             emit;
  lsh_pkg::taps_t   taps;
  lsh_pkg::result_t result;
  lsh_pkg::result_t out_data;

  assign accept = in_valid_i && !in_stall_o;
  assign emit   = (row_q >= RW'(2)) && (col_q >= CW'(2));

  // Advance the raster position; wrap the row, then the frame.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_q >= last_col_q) begin
        col_d = '0;
        row_d = (row_q >= last_row_q) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Geometry is held as the last column and row index, saturated on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= CW'(lsh_pkg::last_index(lsh_pkg::ResetWidth, MAX_WIDTH));
      last_row_q <= RW'(lsh_pkg::last_index(lsh_pkg::ResetHeight, MAX_HEIGHT));
      gain_q     <= lsh_pkg::ResetGain;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lsh_pkg::RegFrameWidth: begin
          last_col_q <= CW'(lsh_pkg::last_index(
              int'(cfg_data_i[lsh_pkg::FrameWidthW-1:0]), MAX_WIDTH));
        end
        lsh_pkg::RegFrameHeight: begin
          last_row_q <= RW'(lsh_pkg::last_index(
              int'(cfg_data_i[lsh_pkg::FrameHeightW-1:0]), MAX_HEIGHT));
        end
        lsh_pkg::RegSharpenGain: begin
          gain_q <= $signed(cfg_data_i[lsh_pkg::GainW-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= '0;
      win_up_q     <= '0;
      win_centre_q <= '0;
      win_down_q   <= '0;
    end else if (accept) begin
      win_left_q   <= win_centre_q;
      win_up_q     <= top_rd;
      win_centre_q <= mid_rd;
      win_down_q   <= pixel_in_i;
    end
  end

  lsh_line_buf #(
    .Depth (MAX_WIDTH),
    .AddrW (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .we_i      (accept),
    .wr_addr_i (col_q),
    .rd_addr_i (col_d),
    .pixel_i   (pixel_in_i),
    .top_o     (top_rd),
    .mid_o     (mid_rd)
  );

  assign taps.up     = win_up_q;
  assign taps.left   = win_left_q;
  assign taps.centre = win_centre_q;
  assign taps.right  = mid_rd;
  assign taps.down   = win_down_q;

  lsh_kernel u_kernel (
    .taps_i  (taps),
    .gain_i  (gain_q),
    .pixel_o (result.pixel)
  );

  assign result.last = (row_q == last_row_q) && (col_q == last_col_q);

  lsh_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && emit),
    .push_data_i (result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .full_o      (in_stall_o)
  );

  assign pixel_out_o  = out_data.pixel;
  assign frame_last_o = out_data.last;

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= CW'(MAX_WIDTH - 1))
    else $error("column count beyond line store depth");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (row_q == last_row_q) && (col_q == last_col_q))
      |=> ((row_q == '0) && (col_q == '0)))
    else $error("raster position did not wrap after the last item of the frame");

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod    = 8;
  localparam int MaxWidth     = 1024;
  localparam int MaxHeight    = 4096;
  localparam int RandomItems  = 400;
  localparam int LongHold     = 300;
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 10;
  localparam int IdleLimit    = 2000;
  // index that maps to no register
  localparam logic [lsh_pkg::CfgIdxW-1:0] RegSpare = 2'd3;

  typedef enum int {TexNoise, TexSmooth, TexBinary, TexRamp} texture_e;

  // Tracks line store, window and counters; queues the sharpened pixels due.
  class SharpenTracker;
    logic [lsh_pkg::PixW-1:0]         line_mem [2*MaxWidth];
    logic [lsh_pkg::PixW-1:0]         win [6];
    int                               col, row;
    logic [lsh_pkg::FrameWidthW-1:0]  width_reg;
    logic [lsh_pkg::FrameHeightW-1:0] height_reg;
    logic signed [lsh_pkg::GainW-1:0] gain_reg;
    lsh_pkg::result_t                 expected_pixels [$];
    int                               errors, pixels_in, pixels_out, frame_ends, reg_writes;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col        = 0;
      row        = 0;
      width_reg  = lsh_pkg::FrameWidthW'(lsh_pkg::ResetWidth);
      height_reg = lsh_pkg::FrameHeightW'(lsh_pkg::ResetHeight);
      gain_reg   = lsh_pkg::ResetGain;
      errors     = 0;
      pixels_in  = 0;
      pixels_out = 0;
      frame_ends = 0;
      reg_writes = 0;
    endfunction

    function int clamp_dim(int v, int hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int eff_width();
      return clamp_dim(int'(width_reg), MaxWidth);
    endfunction

    function int eff_height();
      return clamp_dim(int'(height_reg), MaxHeight);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function bit at_frame_start();
      return col == 0 && row == 0;
    endfunction

    // Items still needed to close the current frame under the given geometry.
    function int items_to_frame_end(int w, int h);
      int row_rem;
      row_rem = (col >= w) ? 1 : w - col;
      if (row + 1 >= h) return row_rem;
      return row_rem + (h - 1 - row) * w;
    endfunction

    function logic [lsh_pkg::PixW-1:0] sharpened(int up, int left, int centre, int right,
                                                 int down);
      int     lap;
      longint total;
      longint q;
      lap   = up + down + left + right - 4 * centre;
      total = longint'(centre) * 256 + longint'(gain_reg) * lap;
      if (total <= 0) return '0;
      q = total / 256;
      if (q > 255) q = 255;
      return q[lsh_pkg::PixW-1:0];
    endfunction

    function void note_config(logic [lsh_pkg::CfgIdxW-1:0] idx,
                              logic [lsh_pkg::CfgDataW-1:0] data);
      reg_writes++;
      case (idx)
        lsh_pkg::RegFrameWidth: begin
          width_reg = data[lsh_pkg::FrameWidthW-1:0];
        end
        lsh_pkg::RegFrameHeight: begin
          height_reg = data[lsh_pkg::FrameHeightW-1:0];
        end
        lsh_pkg::RegSharpenGain: begin
          gain_reg = $signed(data);
        end
        default: begin
        end
      endcase
    endfunction

    function void note_pixel(logic [lsh_pkg::PixW-1:0] px);
      int                       w, h, c;
      logic [lsh_pkg::PixW-1:0] top, mid;
      lsh_pkg::result_t         due;
      w   = eff_width();
      h   = eff_height();
      c   = col % MaxWidth;
      top = line_mem[MaxWidth + c];
      mid = line_mem[c];
      pixels_in++;
      // window columns: [0..2] two back, [3..5] one back; top, middle, bottom
      if (row >= 2 && col >= 2) begin
        due.pixel = sharpened(win[3], win[1], win[4], mid, win[5]);
        due.last  = (row == h - 1 && col == w - 1);
        expected_pixels.push_back(due);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = px;
      line_mem[MaxWidth + c] = mid;
      line_mem[c]            = px;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_result(logic [lsh_pkg::PixW-1:0] pix, logic last);
      lsh_pkg::result_t want;
      pixels_out++;
      if (last) frame_ends++;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel_out %0d frame_last %0b", $time, pix, last);
        return;
      end
      want = expected_pixels.pop_front();
      if (want.pixel !== pix) begin
        errors++;
        $display("%0t: pixel_out expected %0d, got %0d", $time, want.pixel, pix);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: frame_last expected %0b, got %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [lsh_pkg::PixW-1:0]     pixel_in_i  = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [lsh_pkg::PixW-1:0]     pixel_out_o;
  logic                         frame_last_o;
  logic                         cfg_we_i    = 1'b0;
  logic [lsh_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [lsh_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  bit            long_hold_req = 1'b0;
  int            quiet_cycles  = 0;
  SharpenTracker tracker;

  laplacian_sharpen_3x3 #(
    .MAX_WIDTH  (MaxWidth),
    .MAX_HEIGHT (MaxHeight)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tracker.check_result(pixel_out_o, frame_last_o);
      if (in_valid_i && !in_stall_o) tracker.note_pixel(pixel_in_i);
      if (cfg_we_i) tracker.note_config(cfg_index_i, cfg_data_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("Timeout: nothing moved for %0d cycles", IdleLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stretches of back-pressure, mostly short, now and then long.
  initial begin
    int  r, len;
    bit  hold;
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 1'b1;
        len  = LongHold;
      end else if (r < 15) begin
        hold = 1'b0;
        len  = $urandom_range(20, 80);
      end else if (r < 55) begin
        hold = 1'b0;
        len  = $urandom_range(1, 4);
      end else if (r < 90) begin
        hold = 1'b1;
        len  = $urandom_range(1, 3);
      end else if (r < 98) begin
        hold = 1'b1;
        len  = $urandom_range(4, 12);
      end else begin
        hold = 1'b1;
        len  = $urandom_range(20, 40);
      end
      out_stall_i <= hold;
      repeat (len) @(posedge clk_i);
    end
  end

  task automatic send_pixel(input logic [lsh_pkg::PixW-1:0] px, input bit steady);
    int r, gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!steady) begin
      if (r < 50) gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop sending, wait for every pixel due, then let the pipeline settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [lsh_pkg::CfgDataW-1:0] wdata,
                              input logic [lsh_pkg::CfgDataW-1:0] hdata,
                              input logic [lsh_pkg::CfgDataW-1:0] gdata, input bit with_gain);
    if ($urandom_range(0, 4) == 0) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= RegSpare;
      cfg_data_i  <= lsh_pkg::CfgDataW'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b1;
    cfg_index_i <= lsh_pkg::RegFrameWidth;
    cfg_data_i  <= wdata;
    @(posedge clk_i);
    cfg_index_i <= lsh_pkg::RegFrameHeight;
    cfg_data_i  <= hdata;
    @(posedge clk_i);
    if (with_gain) begin
      cfg_index_i <= lsh_pkg::RegSharpenGain;
      cfg_data_i  <= gdata;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int n, input texture_e tex, input int hold_at);
    int                       base, tmp;
    bit                       steady;
    logic [lsh_pkg::PixW-1:0] px;
    base   = $urandom_range(0, 255);
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) long_hold_req = 1'b1;
      case (tex)
        TexSmooth: begin
          tmp = base + int'($urandom_range(0, 24)) - 12;
          px  = (tmp < 0) ? '0 : (tmp > 255) ? lsh_pkg::PixMax : tmp[lsh_pkg::PixW-1:0];
        end
        TexBinary: begin
          px = $urandom_range(0, 1) ? lsh_pkg::PixMax : '0;
        end
        TexRamp: begin
          tmp = base + i * 5;
          px  = tmp[lsh_pkg::PixW-1:0];
        end
        default: begin
          px = lsh_pkg::PixW'($urandom);
        end
      endcase
      send_pixel(px, steady);
    end
    drain_results();
  endtask

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(3, 10);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 85) return $urandom_range(11, 40);
    if (r < 90) return MaxWidth;
    if (r < 95) return 2047;
    return $urandom_range(41, 2047);
  endfunction

  function automatic int pick_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(3, 8);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 85) return $urandom_range(9, 40);
    if (r < 90) return MaxHeight;
    if (r < 95) return 8191;
    return $urandom_range(41, 8191);
  endfunction

  function automatic logic [lsh_pkg::CfgDataW-1:0] pick_gain();
    int r, g;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 5))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        3: return 16'h0100;
        4: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    if (r < 6) begin
      g = int'($urandom_range(0, 1536)) - 768;
      return g[lsh_pkg::CfgDataW-1:0];
    end
    return lsh_pkg::CfgDataW'($urandom);
  endfunction

  initial begin
    logic [lsh_pkg::PixW-1:0]     corner_frame [9];
    logic [lsh_pkg::PixW-1:0]     narrow_frame [12];
    logic [lsh_pkg::CfgDataW-1:0] wdata, hdata;
    int                  random_items, phases, lim, w_val, h_val, w_eff, h_eff, rem, n, hold_at;

    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest frame from under-range geometry writes, gain left at reset
    corner_frame = '{8'd0, 8'd255, 8'd17, 8'd200, 8'd90, 8'd60, 8'd255, 8'd128, 8'd0};
    program_regs(16'hF800, 16'hE002, 16'h0000, 1'b0);
    foreach (corner_frame[i]) send_pixel(corner_frame[i], 1'b0);
    drain_results();

    // most negative gain: one pixel clamps low, the other high
    narrow_frame = '{8'd255, 8'd0, 8'd255, 8'd0,
                     8'd0, 8'd0, 8'd255, 8'd0,
                     8'd255, 8'd0, 8'd255, 8'd255};
    program_regs(16'h0004, 16'h0003, 16'h8000, 1'b1);
    foreach (narrow_frame[i]) send_pixel(narrow_frame[i], 1'b0);
    drain_results();

    // full frame of moderate size; hold the output for a long stretch early on
    program_regs(16'h0018, 16'h0008, pick_gain(), 1'b1);
    run_phase(tracker.items_to_frame_end(24, 8), TexSmooth, 16);

    random_items = 0;
    phases       = 0;
    while (random_items < RandomItems) begin
      if (tracker.at_frame_start()) begin
        w_val = pick_width();
      end else begin
        // mid-frame: only narrow, so no unwritten line entry is ever read
        lim = tracker.eff_width();
        if (lim > 10 && $urandom_range(0, 3) != 0) lim = 10;
        w_val = $urandom_range(0, lim);
      end
      h_val = pick_height();
      w_eff = tracker.clamp_dim(w_val, MaxWidth);
      h_eff = tracker.clamp_dim(h_val, MaxHeight);
      wdata = lsh_pkg::CfgDataW'($urandom);
      wdata[lsh_pkg::FrameWidthW-1:0] = w_val[lsh_pkg::FrameWidthW-1:0];
      hdata = lsh_pkg::CfgDataW'($urandom);
      hdata[lsh_pkg::FrameHeightW-1:0] = h_val[lsh_pkg::FrameHeightW-1:0];
      program_regs(wdata, hdata, pick_gain(), 1'b1);

      rem = tracker.items_to_frame_end(w_eff, h_eff);
      if (w_eff * h_eff > 400) begin
        n = $urandom_range(1, (rem < 300) ? rem : 300);
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, rem);
      end else begin
        n = rem;
        if ($urandom_range(0, 2) == 0) n += w_eff * h_eff;
      end
      hold_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, n - 1)) : -1;
      run_phase(n, texture_e'($urandom_range(0, 3)), hold_at);
      random_items += n;
      phases++;
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d pixels, checked %0d sharpened pixels, %0d of them frame ends.",
             tracker.pixels_in, tracker.pixels_out, tracker.frame_ends);
    $display("%0d register writes over %0d random phases, mid-frame geometry changes included.",
             tracker.reg_writes, phases);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lsh_pkg.sv
design/lsh_line_buf.sv
design/lsh_kernel.sv
design/lsh_out_buf.sv
design/laplacian_sharpen_3x3.sv
tb/testbench.sv
